// ===== hdl/red_pkg.sv =====
// Shared types and constants for the random early detection drop decision block.
package red_pkg;

  // Scale of the weighted average (one million) and its factorization 2^6 * 15625
  localparam int unsigned SCALE       = 1000000;
  localparam int unsigned SCALE_SHIFT = 6;
  localparam int unsigned DIV_K       = 15625;

  // Field and state widths
  localparam int unsigned WEIGHT_W  = 20;
  localparam int unsigned THRESH_W  = 16;
  localparam int unsigned QLEN_W    = 16;
  localparam int unsigned RAND_W    = 32;
  localparam int unsigned AVG_W     = 40;
  localparam int unsigned AVG_INT_W = 21;
  localparam int unsigned PROB_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // Constant divider: one radix-16 digit per step
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned DQ_W       = 56;
  localparam int unsigned DREM_W     = 14;
  localparam int unsigned DIV1_STEPS = 14;
  localparam int unsigned DIV2_STEPS = 9;
  localparam int unsigned PDIV_STEPS = 7;
  localparam int unsigned CNT_W      = 4;

  // Percentage scale for the drop probability
  localparam int unsigned PROB_MAX = 100;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd2;

  // Register reset values
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 20'd2000;
  localparam logic [THRESH_W-1:0] MIN_RST    = 16'd1000;
  localparam logic [THRESH_W-1:0] MAX_RST    = 16'd5000;

  // Zone codes
  localparam logic [1:0] ZONE_BELOW = 2'd0;
  localparam logic [1:0] ZONE_MID   = 2'd1;
  localparam logic [1:0] ZONE_ABOVE = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic mul_q;
    logic div_load;
    logic div_step;
    logic sum;
    logic cmp;
    logic pdiv_step;
    logic publish;
  } red_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mid_zone;
    logic out_free;
  } red_sts_t;

  // k times the divider constant, k = 0..15
  function automatic logic [DREM_W+DIG_W-1:0] div_mult(input logic [DIG_W-1:0] k);
    logic [DREM_W+DIG_W-1:0] r;
    r = (DREM_W+DIG_W)'(k) * (DREM_W+DIG_W)'(DIV_K);
    return r;
  endfunction

endpackage

// ===== hdl/red_ctrl.sv =====
// Sequencing state machine for the drop decision datapath.
module red_ctrl
  import red_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  red_sts_t sts,
  output red_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_MUL_LO = 11'b00000000010,
    S_MUL_HI = 11'b00000000100,
    S_MUL_Q  = 11'b00000001000,
    S_DLOAD  = 11'b00000010000,
    S_DIV1   = 11'b00000100000,
    S_SUM    = 11'b00001000000,
    S_DIV2   = 11'b00010000000,
    S_CMP    = 11'b00100000000,
    S_PDIV   = 11'b01000000000,
    S_PUB    = 11'b10000000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // Next state, step counter and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MUL_Q;
      end
      S_MUL_Q: begin
        cmd.mul_q  = 1'b1;
        state_next = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        cnt_next     = CNT_W'(DIV1_STEPS - 1);
        state_next   = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == '0) state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        cnt_next   = CNT_W'(DIV2_STEPS - 1);
        state_next = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == '0) state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp  = 1'b1;
        cnt_next = CNT_W'(PDIV_STEPS - 1);
        if (sts.mid_zone) state_next = S_PDIV;
        else state_next = S_PUB;
      end
      S_PDIV: begin
        cmd.pdiv_step = 1'b1;
        cnt_next      = cnt - 1'b1;
        if (cnt == '0) state_next = S_PUB;
      end
      S_PUB: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== hdl/red_dp.sv =====
// Datapath: average update, constant divider, percentage divider and result register.
module red_dp
  import red_pkg::*;
#(
  parameter int unsigned QUEUE_LEN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  red_cmd_t            cmd,
  output red_sts_t            sts,
  input  logic [QLEN_W-1:0]   qdepth,
  input  logic [RAND_W-1:0]   random_word,
  input  logic [WEIGHT_W-1:0] ewma_weight,
  input  logic [THRESH_W-1:0] min_thresh,
  input  logic [THRESH_W-1:0] max_thresh,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                drop,
  output logic [1:0]          zone,
  output logic [QLEN_W-1:0]   avg_len,
  output logic [PROB_W-1:0]   drop_pct
);

  localparam int unsigned QL_W  = (QUEUE_LEN_BITS < QLEN_W) ? QUEUE_LEN_BITS : QLEN_W;
  localparam int unsigned ACC_W = 2 * AVG_W - WEIGHT_W;
  localparam int unsigned PROD_W = 2 * WEIGHT_W;
  localparam int unsigned PNUM_W = THRESH_W + PROB_W;
  localparam int unsigned PDEN_W = THRESH_W + PROB_W - 1;
  localparam int unsigned HALF_W = AVG_W / 2;

  // Operand and state registers
  logic [QL_W-1:0]     qlen;
  logic [WEIGHT_W-1:0] wsat, wcomp;
  logic [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]    acc;
  logic [AVG_W-1:0]    avg_fix;
  logic [DQ_W-1:0]     dq;
  logic [DREM_W-1:0]   drem;
  logic [1:0]          zone_r;
  logic [QLEN_W-1:0]   avg_len_r;
  logic [PNUM_W-1:0]   prem;
  logic [PDEN_W-1:0]   pden;
  logic [PROB_W-1:0]   pq;
  logic [RAND_W-1:0]   rnd_sh;
  logic [PROB_W-1:0]   rmod;
  logic [4:0]          rmod_cnt;

  // Combinational helpers
  logic [WEIGHT_W-1:0]       mul_a, mul_b, w_in;
  logic [DREM_W+DIG_W-1:0]   dig_t, dig_r;
  logic [DIG_W-1:0]          dig_q;
  logic [AVG_W:0]            sum_full;
  logic [AVG_W-1:0]          avg_next;
  logic [AVG_INT_W-1:0]      avg_int;
  logic                      ge_max, le_min;
  logic [THRESH_W-1:0]       diff, den;
  logic [PNUM_W-1:0]         pnum;
  logic                      pge;
  logic [PROB_W+1:0]         rm_t;
  logic [PROB_W-1:0]         rm_r;
  logic                      drop_d;

  // Saturate weight to one million
  assign w_in = (ewma_weight > WEIGHT_W'(SCALE)) ? WEIGHT_W'(SCALE) : ewma_weight;

  // Shared multiplier operand select
  always_comb begin
    mul_a = wcomp;
    mul_b = avg_fix[HALF_W-1:0];
    if (cmd.mul_hi) begin
      mul_b = avg_fix[AVG_W-1:HALF_W];
    end else if (cmd.mul_q) begin
      mul_a = wsat;
      mul_b = WEIGHT_W'(qlen);
    end
  end

  // Radix-16 digit of the division by 15625
  always_comb begin
    dig_t = {drem, dq[DQ_W-1 -: DIG_W]};
    dig_q = '0;
    for (int k = 1; k < 16; k++) begin
      if (dig_t >= div_mult(DIG_W'(k))) dig_q = DIG_W'(k);
    end
    dig_r = dig_t - div_mult(dig_q);
  end

  // New scaled average, saturated to 40 bits
  assign sum_full = {1'b0, dq[AVG_W-1:0]} + (AVG_W+1)'(prod);
  assign avg_next = sum_full[AVG_W] ? {AVG_W{1'b1}} : sum_full[AVG_W-1:0];

  // Zone decision on the integer average
  assign avg_int = dq[AVG_INT_W-1:0];
  assign ge_max  = avg_int >= AVG_INT_W'(max_thresh);
  assign le_min  = avg_int <= AVG_INT_W'(min_thresh);
  assign diff    = avg_int[THRESH_W-1:0] - min_thresh;
  assign den     = max_thresh - min_thresh;
  assign pnum    = (PNUM_W'(diff) << 6) + (PNUM_W'(diff) << 5) + (PNUM_W'(diff) << 2);

  // Restoring step of the percentage divide
  assign pge = prem >= PNUM_W'(pden);

  // Two bits a step of random_word mod 100
  always_comb begin
    rm_t = {rmod, rnd_sh[RAND_W-1 -: 2]};
    if (rm_t >= (PROB_W+2)'(3 * PROB_MAX)) rm_r = PROB_W'(rm_t - (PROB_W+2)'(3 * PROB_MAX));
    else if (rm_t >= (PROB_W+2)'(2 * PROB_MAX)) rm_r = PROB_W'(rm_t - (PROB_W+2)'(2 * PROB_MAX));
    else if (rm_t >= (PROB_W+2)'(PROB_MAX)) rm_r = PROB_W'(rm_t - (PROB_W+2)'(PROB_MAX));
    else rm_r = PROB_W'(rm_t);
  end

  assign drop_d = (zone_r == ZONE_ABOVE) || ((zone_r == ZONE_MID) && (rmod < pq));

  assign sts.mid_zone = !ge_max && !le_min;
  assign sts.out_free = !out_valid || out_ready;

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qlen   <= qdepth[QL_W-1:0];
      wsat   <= w_in;
      wcomp  <= WEIGHT_W'(SCALE) - w_in;
      rnd_sh <= random_word;
      rmod   <= '0;
    end else if (rmod_cnt != '0) begin
      rnd_sh <= rnd_sh << 2;
      rmod   <= rm_r;
    end
    if (cmd.mul_lo || cmd.mul_hi || cmd.mul_q) prod <= mul_a * mul_b;
    if (cmd.mul_hi) acc <= ACC_W'(prod);
    if (cmd.mul_q) acc <= acc + {prod, {HALF_W{1'b0}}};
    if (cmd.div_load) begin
      dq   <= DQ_W'(acc[ACC_W-1:SCALE_SHIFT]);
      drem <= '0;
    end else if (cmd.sum) begin
      dq   <= {2'b00, avg_next[AVG_W-1:SCALE_SHIFT], {(DQ_W-2-AVG_W+SCALE_SHIFT){1'b0}}};
      drem <= '0;
    end else if (cmd.div_step) begin
      dq   <= {dq[DQ_W-DIG_W-1:0], dig_q};
      drem <= dig_r[DREM_W-1:0];
    end
    if (cmd.cmp) begin
      zone_r    <= ge_max ? ZONE_ABOVE : (le_min ? ZONE_BELOW : ZONE_MID);
      avg_len_r <= (|avg_int[AVG_INT_W-1:QLEN_W]) ? {QLEN_W{1'b1}} : avg_int[QLEN_W-1:0];
      prem      <= pnum;
      pden      <= {den, {(PROB_W-1){1'b0}}};
      pq        <= '0;
    end else if (cmd.pdiv_step) begin
      if (pge) prem <= prem - PNUM_W'(pden);
      pden <= pden >> 1;
      pq   <= {pq[PROB_W-2:0], pge};
    end
    if (cmd.publish) begin
      drop     <= drop_d;
      zone     <= zone_r;
      avg_len  <= avg_len_r;
      drop_pct <= pq;
    end
  end

  // Control registers and the average state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rmod_cnt  <= '0;
      avg_fix   <= '0;
    end else begin
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.load) rmod_cnt <= 5'(RAND_W / 2);
      else if (rmod_cnt != '0) rmod_cnt <= rmod_cnt - 1'b1;
      if (cmd.sum) avg_fix <= avg_next;
    end
  end

endmodule

// ===== hdl/red_drop_decision.sv =====
// Top level of the random early detection drop decision block.
// Each accepted packet updates a weighted average queue length held scaled by one
// million and returns one decision: drop, zone, integer average and drop percentage.
// A packet occupies the block from its input transfer until its result is loaded; the
// next packet is taken once the block is idle again, and the result is loaded only
// when the output register is free. The block uses the shared radix-16 divider by the
// constant 15625, run twice (14 and 9 digits), and the bit-serial percentage divide (7
// steps), run only when the average lands strictly between the thresholds. The result
// sits in an output register, so the next packet is accepted while the previous
// result still waits for its transfer. Configuration registers take effect on the next
// packet and should be written while the block is idle.
module red_drop_decision
  import red_pkg::*;
#(
  parameter int unsigned QUEUE_LEN_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [QLEN_W-1:0]    qdepth,
  input  logic [RAND_W-1:0]    random_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 drop,
  output logic [1:0]           zone,
  output logic [QLEN_W-1:0]    avg_len,
  output logic [PROB_W-1:0]    drop_pct
);

  logic [WEIGHT_W-1:0] ewma_weight;
  logic [THRESH_W-1:0] min_thresh;
  logic [THRESH_W-1:0] max_thresh;
  red_cmd_t            cmd;
  red_sts_t            sts;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ewma_weight <= WEIGHT_RST;
      min_thresh  <= MIN_RST;
      max_thresh  <= MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WEIGHT: ewma_weight <= cfg_data;
        REG_MIN:    min_thresh  <= cfg_data[THRESH_W-1:0];
        REG_MAX:    max_thresh  <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  red_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  red_dp #(
    .QUEUE_LEN_BITS (QUEUE_LEN_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .qdepth      (qdepth),
    .random_word (random_word),
    .ewma_weight (ewma_weight),
    .min_thresh  (min_thresh),
    .max_thresh  (max_thresh),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drop        (drop),
    .zone        (zone),
    .avg_len     (avg_len),
    .drop_pct    (drop_pct)
  );

  // Above the max threshold every packet drops
  a_above_drops: assert property (@(posedge clk) disable iff (rst)
    out_valid && (zone == ZONE_ABOVE) |-> drop)
    else $error("packet above max threshold not dropped");

  // Below the min threshold nothing drops and the probability is zero
  a_below_passes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (zone == ZONE_BELOW) |-> !drop && (drop_pct == '0))
    else $error("packet below min threshold dropped or nonzero probability");

  // Probability stays a percentage below one hundred and the zone code stays valid
  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drop_pct < PROB_W'(PROB_MAX)) && (zone != 2'd3))
    else $error("drop probability or zone out of range");

  // One packet at a time: an input transfer closes the input side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second packet taken while one is in progress");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the random early detection drop decision block.
module testbench
  import red_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QLEN_BITS  = 16;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned RAND_PHASES = 26;
  localparam int unsigned PHASE_PKTS  = 50;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [63:0] AVG_SAT = (64'd1 << AVG_W) - 64'd1;

  // One decision as the block reports it
  typedef struct packed {
    logic              drop;
    logic [1:0]        zone;
    logic [QLEN_W-1:0] avg_len;
    logic [PROB_W-1:0] drop_pct;
  } red_decision_t;

  // Weighted-average predictor and the queue of decisions still owed
  class red_scoreboard;
    bit [WEIGHT_W-1:0] weight;
    bit [THRESH_W-1:0] min_th;
    bit [THRESH_W-1:0] max_th;
    bit [AVG_W-1:0]    avg_fix;
    red_decision_t     decision_q[$];
    int unsigned       failures;

    function new();
      weight   = WEIGHT_RST;
      min_th   = MIN_RST;
      max_th   = MAX_RST;
      avg_fix  = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] data);
      case (idx)
        REG_WEIGHT: weight = data;
        REG_MIN:    min_th = data[THRESH_W-1:0];
        REG_MAX:    max_th = data[THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    // Update the average for one accepted packet and queue its decision
    function void note_packet(logic [QLEN_W-1:0] qlen, logic [RAND_W-1:0] rnd);
      bit [63:0] w;
      bit [63:0] kept;
      bit [63:0] next_avg;
      bit [63:0] avg;
      bit [63:0] prob;
      bit [63:0] qmask;
      red_decision_t d;
      qmask = (64'd1 << QLEN_BITS) - 64'd1;
      w = (weight > SCALE) ? 64'(SCALE) : 64'(weight);
      kept = ((64'(SCALE) - w) * 64'(avg_fix)) / 64'(SCALE);
      next_avg = kept + w * (64'(qlen) & qmask);
      if (next_avg > AVG_SAT) next_avg = AVG_SAT;
      avg_fix = next_avg[AVG_W-1:0];
      avg = next_avg / 64'(SCALE);
      prob = 0;
      d.drop = 1'b0;
      if (avg >= 64'(max_th)) begin
        d.zone = ZONE_ABOVE;
        d.drop = 1'b1;
      end else if (avg <= 64'(min_th)) begin
        d.zone = ZONE_BELOW;
      end else begin
        d.zone = ZONE_MID;
        prob = ((avg - 64'(min_th)) * 64'(PROB_MAX)) / (64'(max_th) - 64'(min_th));
        d.drop = (64'(rnd) % 64'(PROB_MAX)) < prob;
      end
      d.avg_len  = (avg > 64'hFFFF) ? 16'hFFFF : avg[QLEN_W-1:0];
      d.drop_pct = prob[PROB_W-1:0];
      decision_q.push_back(d);
    endfunction

    // Compare one transferred decision with the oldest one owed
    function void check_decision(logic drop, logic [1:0] zone, logic [QLEN_W-1:0] avg_len,
                                 logic [PROB_W-1:0] drop_pct);
      red_decision_t want;
      if (decision_q.size() == 0) begin
        $error("decision transferred with no packet outstanding");
        failures++;
        return;
      end
      want = decision_q.pop_front();
      if (drop !== want.drop) begin
        $error("drop: expected %0d, actual %0d", want.drop, drop);
        failures++;
      end
      if (zone !== want.zone) begin
        $error("zone: expected %0d, actual %0d", want.zone, zone);
        failures++;
      end
      if (avg_len !== want.avg_len) begin
        $error("avg_len: expected %0d, actual %0d", want.avg_len, avg_len);
        failures++;
      end
      if (drop_pct !== want.drop_pct) begin
        $error("drop_pct: expected %0d, actual %0d", want.drop_pct, drop_pct);
        failures++;
      end
    endfunction

    function int pending();
      return decision_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WEIGHT_W-1:0]  cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [QLEN_W-1:0]    qdepth;
  logic [RAND_W-1:0]    random_word;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 drop;
  logic [1:0]           zone;
  logic [QLEN_W-1:0]    avg_len;
  logic [PROB_W-1:0]    drop_pct;

  red_scoreboard sb;
  int unsigned   ready_run = 0;
  int unsigned   idle_cycles = 0;

  red_drop_decision #(
    .QUEUE_LEN_BITS(QLEN_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .qdepth(qdepth),
    .random_word(random_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drop(drop),
    .zone(zone),
    .avg_len(avg_len),
    .drop_pct(drop_pct)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side in runs: long stalls, long open stretches, short jitter
  always @(posedge clk) begin
    if (ready_run == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_ready <= 1'b0;
          ready_run <= $urandom_range(1, 40);
        end
        1: begin
          out_ready <= 1'b1;
          ready_run <= $urandom_range(100, 400);
        end
        default: begin
          out_ready <= 1'($urandom_range(0, 1));
          ready_run <= $urandom_range(1, 6);
        end
      endcase
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // Check every decision transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_decision(drop, zone, avg_len, drop_pct);
    end
  end

  // End the run when nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one packet and hold it until its transfer
  task automatic send_packet(input logic [QLEN_W-1:0] q, input logic [RAND_W-1:0] r);
    in_valid    <= 1'b1;
    qdepth      <= q;
    random_word <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_packet(q, r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Drain all owed decisions
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Drain, then load all registers plus one write to the unused index
  task automatic reprogram(input logic [WEIGHT_W-1:0] w, input logic [WEIGHT_W-1:0] mn,
                           input logic [WEIGHT_W-1:0] mx);
    drain();
    write_reg(REG_WEIGHT, w);
    write_reg(REG_MIN, mn);
    write_reg(REG_MAX, mx);
    write_reg(REG_UNUSED, WEIGHT_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned w;
    int unsigned mn;
    int unsigned mx;
    int unsigned lo_th;
    int unsigned hi_th;
    int unsigned span;
    int unsigned q_lo;
    int unsigned q_hi;
    int unsigned burst_left;
    int unsigned gap;
    bit          gaps_on;
    logic [QLEN_W-1:0] q;
    logic [RAND_W-1:0] r;

    sb          = new();
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_WEIGHT;
    cfg_data    = '0;
    in_valid    = 1'b0;
    qdepth      = '0;
    random_word = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: slow average from zero
    send_packet(16'hFFFF, 32'h0);
    send_packet(16'hFFFF, 32'hFFFF_FFFF);

    // Full weight: average equals queue length; walk through the zones
    reprogram(20'(SCALE), 20'd1000, 20'd5000);
    send_packet(16'd0, 32'd0);
    send_packet(16'd1000, 32'd0);
    send_packet(16'd1001, 32'd0);
    send_packet(16'd3000, 32'd49);
    send_packet(16'd3000, 32'd50);
    send_packet(16'd3000, 32'hFFFF_FFFF);
    send_packet(16'd4999, 32'd98);
    send_packet(16'd4999, 32'd99);
    send_packet(16'd5000, 32'd0);
    send_packet(16'hFFFF, 32'hFFFF_FFFF);

    // Weight above one million saturates; widest threshold band
    reprogram(20'hFFFFF, 20'd0, 20'd65535);
    send_packet(16'hFFFF, 32'd0);
    send_packet(16'd0, 32'd0);
    send_packet(16'd32768, 32'd49);
    send_packet(16'd1, 32'd0);

    // Crossed thresholds: drop test wins, then pass test
    reprogram(20'(SCALE), 20'd5000, 20'd1000);
    send_packet(16'd3000, 32'd0);
    send_packet(16'd500, 32'd0);

    // Equal thresholds
    reprogram(20'(SCALE), 20'd2000, 20'd2000);
    send_packet(16'd2000, 32'd7);
    send_packet(16'd1999, 32'd7);

    // Zero weight freezes the average
    reprogram(20'd0, 20'd0, 20'd1);
    send_packet(16'hFFFF, 32'd0);
    send_packet(16'h5555, 32'hAAAA_AAAA);

    // Half weight with upper data bits set on the thresholds
    reprogram(20'd500000, 20'hF0000, 20'hF00C8);
    send_packet(16'd301, 32'd12);
    send_packet(16'd57, 32'd3);

    // Random phases: new settings each time, packets clustered around the band
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 7))
        0: w = 0;
        1: w = SCALE;
        2: w = 20'hFFFFF;
        3: w = $urandom_range(1, 5000);
        default: w = $urandom_range(50000, SCALE);
      endcase
      case ($urandom_range(0, 7))
        0: begin
          mn = 0;
          mx = 65535;
        end
        1: begin
          mn = $urandom_range(0, 65535);
          mx = mn;
        end
        2: begin
          mx = $urandom_range(0, 60000);
          mn = mx + $urandom_range(1, 5535);
        end
        3: begin
          mn = 0;
          mx = $urandom_range(1, 300);
        end
        default: begin
          mn = $urandom_range(0, 60000);
          mx = mn + $urandom_range(1, 5535);
        end
      endcase
      reprogram(WEIGHT_W'(w), {4'($urandom), 16'(mn)}, {4'($urandom), 16'(mx)});

      lo_th = (mn < mx) ? mn : mx;
      hi_th = (mn < mx) ? mx : mn;
      span  = hi_th - lo_th + 256;
      q_lo  = (lo_th > span) ? lo_th - span : 0;
      q_hi  = (hi_th + span > 65535) ? 65535 : hi_th + span;
      gaps_on    = ($urandom_range(0, 3) != 0);
      burst_left = 0;

      for (int i = 0; i < PHASE_PKTS; i++) begin
        // Idle between bursts
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          gap = gaps_on ? $urandom_range(0, 45) : 0;
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        if ($urandom_range(0, 7) == 0) q = QLEN_W'($urandom);
        else q = QLEN_W'($urandom_range(q_lo, q_hi));
        case ($urandom_range(0, 15))
          0: r = '0;
          1: r = '1;
          default: r = $urandom;
        endcase
        send_packet(q, r);
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
